### src/prl_pkg.sv
package prl_pkg;

	// Field widths fixed by the port definition
	localparam int CMD_W     = 2;
	localparam int PAGE_W    = 6;
	localparam int VSTAMP_W  = 32;
	localparam int PIU_W     = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Defaults for the top-level parameters
	localparam int MAX_PAGES_DEF  = 64;
	localparam int STAMP_BITS_DEF = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

	// Policy codes
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

	localparam logic [PIU_W-1:0] PAGES_IN_USE_RST = 7'd64;

	// Control of one compare step of the victim scan
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

### src/prl_cmd_if.sv
interface prl_cmd_if;
	import prl_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [PAGE_W-1:0] page_index;

	modport source (output valid, output cmd, output page_index, input ready);
	modport sink (input valid, input cmd, input page_index, output ready);
endinterface

### src/prl_res_if.sv
interface prl_res_if;
	import prl_pkg::*;

	logic                valid;
	logic                ready;
	logic [PAGE_W-1:0]   victim_page;
	logic [VSTAMP_W-1:0] victim_stamp;

	modport source (output valid, output victim_page, output victim_stamp, input ready);
	modport sink (input valid, input victim_page, input victim_stamp, output ready);
endinterface

### src/page_replacement_lru_fifo.sv
// LRU / FIFO page replacement victim selector. Each page entry has a use stamp
// and a load stamp, held in two single-port-write, registered-read memories of
// MAX_PAGES entries. An access command (cmd 0) bumps the access counter and, in
// LRU mode, writes the new count into the page's use stamp; a load command
// (cmd 1) in FIFO mode writes the load counter into the page's load stamp and
// then bumps that counter. Both return nothing; a command naming a page at
// or beyond the live page count is dropped without effect. A select command
// (cmd 2) walks pages 0 .. live-1 through the memory read port, one entry
// per cycle, and returns the page with the smallest stamp for the current
// policy (lowest index on ties) together with the low 32 bits of that stamp.
// From acceptance the select passes through the reads, the registered memory
// read, the compare register, and the load of the output register, which
// waits until that register is free. The live count is pages_in_use, with 0
// read as 1 and values above MAX_PAGES read as MAX_PAGES. After reset the
// block zeroes every entry of both memories before it takes the first item;
// register writes are taken at all times but must only be issued while the
// block is idle.
module page_replacement_lru_fifo #(
	parameter int MAX_PAGES  = prl_pkg::MAX_PAGES_DEF,
	parameter int STAMP_BITS = prl_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	prl_cmd_if.sink                       cmd_ch,
	prl_res_if.source                     res_ch,
	input  logic                          cfg_we,
	input  logic [prl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [prl_pkg::CFG_W-1:0]     cfg_wdata
);
	import prl_pkg::*;

	localparam int ADDR_W  = $clog2(MAX_PAGES);
	localparam int CNT_RAW = $clog2(MAX_PAGES + 1);
	localparam int CNT_W   = (CNT_RAW > PIU_W) ? CNT_RAW : PIU_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [ADDR_W-1:0]     clr_idx_q;
	logic [ADDR_W-1:0]     rd_idx_q;
	logic                  iss_q;

	logic                  policy_q;
	logic [PIU_W-1:0]      piu_q;
	logic [STAMP_BITS-1:0] access_cnt_q;
	logic [STAMP_BITS-1:0] load_cnt_q;

	logic                  res_valid_q;
	logic [PAGE_W-1:0]     res_page_q;
	logic [VSTAMP_W-1:0]   res_stamp_q;

	scan_ctl_t             cmp_ctl_s1;
	logic [ADDR_W-1:0]     cmp_idx_s1;

	logic [CNT_W-1:0]      piu_ext;
	logic [CNT_W-1:0]      live;
	logic [CNT_W-1:0]      last_idx;
	logic [CNT_W-1:0]      page_ext;
	logic [ADDR_W-1:0]     page_addr;
	logic                  in_range;
	logic                  in_acc;
	logic                  do_access;
	logic                  do_load;
	logic                  do_select;
	logic                  rd_last;
	logic                  rd_en;

	logic                  use_we;
	logic                  load_we;
	logic [ADDR_W-1:0]     wr_addr;
	logic [STAMP_BITS-1:0] use_wdata;
	logic [STAMP_BITS-1:0] load_wdata;
	logic [STAMP_BITS-1:0] use_rdata;
	logic [STAMP_BITS-1:0] load_rdata;
	logic [STAMP_BITS-1:0] scan_stamp;

	logic [ADDR_W-1:0]     best_idx;
	logic [STAMP_BITS-1:0] best_stamp;
	logic                  scan_done;

	// Live page count: clamp the register into 1 .. MAX_PAGES
	always_comb begin
		piu_ext = CNT_W'(piu_q);
		if (piu_q == '0) begin
			live = CNT_W'(1);
		end else if (piu_ext > CNT_W'(MAX_PAGES)) begin
			live = CNT_W'(MAX_PAGES);
		end else begin
			live = piu_ext;
		end
	end

	assign last_idx  = live - CNT_W'(1);
	assign page_ext  = CNT_W'(cmd_ch.page_index);
	assign page_addr = page_ext[ADDR_W-1:0];
	assign in_range  = page_ext < live;

	// Items are taken only between scans, once the memories are cleared
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign in_acc       = cmd_ch.valid && cmd_ch.ready;
	assign do_access    = in_acc && (cmd_ch.cmd == CMD_ACCESS) && in_range;
	assign do_load      = in_acc && (cmd_ch.cmd == CMD_LOAD) && in_range;
	assign do_select    = in_acc && (cmd_ch.cmd == CMD_SELECT);

	// Write side: the clearing sweep, or a stamp update
	always_comb begin
		if (state_q == ST_CLEAR) begin
			use_we     = 1'b1;
			load_we    = 1'b1;
			wr_addr    = clr_idx_q;
			use_wdata  = '0;
			load_wdata = '0;
		end else begin
			use_we     = do_access && (policy_q == POLICY_LRU);
			load_we    = do_load && (policy_q == POLICY_FIFO);
			wr_addr    = page_addr;
			use_wdata  = access_cnt_q + 1'b1;
			load_wdata = load_cnt_q;
		end
	end

	// Read side: one entry per cycle while the scan issues
	assign rd_en   = (state_q == ST_SCAN) && iss_q;
	assign rd_last = (CNT_W'(rd_idx_q) == last_idx);

	prl_ram #(
		.WIDTH (STAMP_BITS),
		.DEPTH (MAX_PAGES)
	) u_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (wr_addr),
		.wdata (use_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (use_rdata)
	);

	prl_ram #(
		.WIDTH (STAMP_BITS),
		.DEPTH (MAX_PAGES)
	) u_load_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (wr_addr),
		.wdata (load_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (load_rdata)
	);

	// The user must hold policy still for the whole scan (the block does not enforce it), so pick the stamp after the read
	assign scan_stamp = (policy_q == POLICY_LRU) ? use_rdata : load_rdata;

	prl_scan #(
		.ADDR_W  (ADDR_W),
		.STAMP_W (STAMP_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cmp_ctl_s1),
		.idx        (cmp_idx_s1),
		.stamp      (scan_stamp),
		.best_idx   (best_idx),
		.best_stamp (best_stamp),
		.done       (scan_done)
	);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_LRU;
			piu_q    <= PAGES_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_POLICY_MODE:  policy_q <= cfg_wdata[0];
				CFG_PAGES_IN_USE: piu_q    <= cfg_wdata[PIU_W-1:0];
				default: ;
			endcase
		end
	end

	// Counters advance only for commands that name a live page
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_cnt_q <= '0;
			load_cnt_q   <= '0;
		end else begin
			if (do_access) begin
				access_cnt_q <= access_cnt_q + 1'b1;
			end
			if (do_load && (policy_q == POLICY_FIFO)) begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
		end
	end

	// Sequencer: clear sweep, idle, scan, then hand the result over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			iss_q       <= 1'b0;
			cmp_ctl_s1  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			cmp_ctl_s1.vld   <= rd_en;
			cmp_ctl_s1.first <= rd_en && (rd_idx_q == '0);
			cmp_ctl_s1.last  <= rd_en && rd_last;

			// Raise the result as it leaves hand-over, drop it once taken
			if ((state_q == ST_DONE) && (!res_valid_q || res_ch.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ADDR_W'(MAX_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (do_select) begin
						rd_idx_q <= '0;
						iss_q    <= 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (iss_q) begin
						if (rd_last) begin
							iss_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Wait here until the output register is free
					if (!res_valid_q || res_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Index travels alongside the read data
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!res_valid_q || res_ch.ready)) begin
			res_page_q  <= PAGE_W'(best_idx);
			res_stamp_q <= VSTAMP_W'(best_stamp);
		end
	end

	assign res_ch.valid        = res_valid_q;
	assign res_ch.victim_page  = res_page_q;
	assign res_ch.victim_stamp = res_stamp_q;

	// A new result only ever comes out of the hand-over state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside of hand-over");

	// Stamps must not change under a running scan
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!use_we && !load_we))
		else $error("stamp memory written during scan");

	// Every compared entry lies inside the live page range
	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_ctl_s1.vld |-> (CNT_W'(cmp_idx_s1) < live))
		else $error("scan compared an entry beyond the live count");

	// The scan's first compare always seeds the minimum at page zero
	a_first_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_ctl_s1.first |-> (cmp_ctl_s1.vld && (cmp_idx_s1 == '0)))
		else $error("scan seeded from a page other than zero");

	// The chosen victim is a live page
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (CNT_W'(best_idx) < live))
		else $error("victim beyond the live count");
endmodule

### src/prl_ram.sv
module prl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### src/prl_scan.sv
module prl_scan #(
	parameter int ADDR_W  = 6,
	parameter int STAMP_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  prl_pkg::scan_ctl_t   ctl,
	input  logic [ADDR_W-1:0]    idx,
	input  logic [STAMP_W-1:0]   stamp,
	output logic [ADDR_W-1:0]    best_idx,
	output logic [STAMP_W-1:0]   best_stamp,
	output logic                 done
);
	import prl_pkg::*;

	logic [ADDR_W-1:0]  best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               done_q;

	// Strict less-than keeps the lowest index on equal stamps
	always_ff @(posedge clk) begin
		if (ctl.vld && (ctl.first || (stamp < best_stamp_q))) begin
			best_idx_q   <= idx;
			best_stamp_q <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.vld && ctl.last;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_stamp = best_stamp_q;
	assign done       = done_q;
endmodule
